>>> hw/rtl/tlcv_pkg.sv
// Shared types, register codes and reset values of the traffic light color vote unit.
package tlcv_pkg;

  // Output average width is fixed by the result format
  localparam int AVG_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_HUE_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_HUE_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_HUE_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_MIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_MIN       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RED_WEIGHT    = 3'd6;

  // Register reset values
  localparam logic [5:0] WINDOW_LEN_RST    = 6'd20;
  localparam logic [7:0] RED_HUE_MAX_RST   = 8'd10;
  localparam logic [7:0] GREEN_HUE_MIN_RST = 8'd40;
  localparam logic [7:0] GREEN_HUE_MAX_RST = 8'd80;
  localparam logic [7:0] SAT_MIN_RST       = 8'd100;
  localparam logic [7:0] VAL_MIN_RST       = 8'd100;
  localparam logic [3:0] RED_WEIGHT_RST    = 4'd6;

  typedef struct packed {
    logic [5:0] window_len;
    logic [7:0] red_hue_max;
    logic [7:0] green_hue_min;
    logic [7:0] green_hue_max;
    logic [7:0] sat_min;
    logic [7:0] val_min;
    logic [3:0] red_weight;
  } cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic count_en;    // classify and count the accepted pixel
    logic rd_oldest;   // read the oldest history entry
    logic evict;       // drop the entry just read from the sums
    logic write_hist;  // push the box counts into the history
    logic div_load;    // load the serial dividers
    logic div_step;    // one quotient bit
    logic out_load;    // capture the result
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic evict_needed;  // window already holds as many entries as allowed
  } dp_status_t;

endpackage

>>> hw/rtl/tlcv_if.sv
// Pixel and result stream interfaces of the traffic light color vote unit.
interface tlcv_pixel_if import tlcv_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;
  logic       last_pixel;

  modport source (output valid, output hue, output saturation, output brightness,
                  output last_pixel, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input last_pixel, output ready);
endinterface

interface tlcv_result_if import tlcv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             is_red;
  logic [AVG_W-1:0] avg_red;
  logic [AVG_W-1:0] avg_green;

  modport source (output valid, output is_red, output avg_red, output avg_green,
                  input ready);
  modport sink   (input valid, input is_red, input avg_red, input avg_green,
                  output ready);
endinterface

>>> hw/rtl/traffic_light_color_vote_unit.sv
// Top level of the traffic light color vote unit: config, controller and datapath.
//
//  channel  | direction | handshake       | payload
//  ---------+-----------+-----------------+-----------------------------------------
//  in_pix   | sink      | valid / ready   | hue, saturation, brightness, last_pixel
//  out_res  | source    | valid / ready   | is_red, avg_red, avg_green
//  cfg_*    | sink      | cfg_wr_en only  | cfg_index, cfg_data
//
// A pixel without last_pixel is counted as it is taken. A last pixel is counted, the window
// checked, at most one oldest entry evicted, the counts pushed and the bit-serial dividers run
// over SUM_W = COUNT_BITS + clog2(MAX_WINDOW+1) bits (29 by default) for both averages.
// Reset is synchronous and active low; no clearing pass is needed.
// A result waits in the output register while pixels of the next box are taken; a box
// end holds in_pix beyond these steps only while the previous result has not been taken.
module traffic_light_color_vote_unit import tlcv_pkg::*; #(
  parameter int MAX_WINDOW = 32,
  parameter int COUNT_BITS = 23
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tlcv_pixel_if.sink            in_pix,
  tlcv_result_if.source         out_res
);

  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = COUNT_BITS + FILL_W;

  cfg_t       cfg;
  logic       hist_clear;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  tlcv_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .hist_clear (hist_clear)
  );

  tlcv_ctrl #(
    .SUM_W (SUM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_last   (in_pix.last_pixel),
    .in_ready  (in_ready),
    .out_ready (out_res.ready),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  tlcv_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .hist_clear (hist_clear),
    .hue        (in_pix.hue),
    .saturation (in_pix.saturation),
    .brightness (in_pix.brightness),
    .cmd        (cmd),
    .status     (status),
    .is_red     (out_res.is_red),
    .avg_red    (out_res.avg_red),
    .avg_green  (out_res.avg_green)
  );

  assign in_pix.ready  = in_ready;
  assign out_res.valid = out_valid;

  // No pixel beat is taken while the dividers run
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !in_pix.ready)
    else $error("pixel accepted during division");

  // A history push is followed by a divider load
  a_write_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_hist |=> cmd.div_load)
    else $error("divider not loaded after history write");

  // An eviction uses the entry read in the cycle before
  a_evict_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evict |-> $past(cmd.rd_oldest))
    else $error("eviction without history read");

  // A result beat only appears after a result capture
  a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> $past(cmd.out_load))
    else $error("result valid without capture");

endmodule

>>> hw/rtl/tlcv_cfg.sv
// Configuration register file of the traffic light color vote unit.
module tlcv_cfg import tlcv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg,
  output logic                  hist_clear
);

  cfg_t cfg_r;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_len    <= WINDOW_LEN_RST;
      cfg_r.red_hue_max   <= RED_HUE_MAX_RST;
      cfg_r.green_hue_min <= GREEN_HUE_MIN_RST;
      cfg_r.green_hue_max <= GREEN_HUE_MAX_RST;
      cfg_r.sat_min       <= SAT_MIN_RST;
      cfg_r.val_min       <= VAL_MIN_RST;
      cfg_r.red_weight    <= RED_WEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WINDOW_LEN:    cfg_r.window_len    <= cfg_data[5:0];
        REG_RED_HUE_MAX:   cfg_r.red_hue_max   <= cfg_data;
        REG_GREEN_HUE_MIN: cfg_r.green_hue_min <= cfg_data;
        REG_GREEN_HUE_MAX: cfg_r.green_hue_max <= cfg_data;
        REG_SAT_MIN:       cfg_r.sat_min       <= cfg_data;
        REG_VAL_MIN:       cfg_r.val_min       <= cfg_data;
        REG_RED_WEIGHT:    cfg_r.red_weight    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  // A new window length restarts the history
  assign hist_clear = cfg_wr_en && (cfg_index == REG_WINDOW_LEN);

endmodule

>>> hw/rtl/tlcv_ctrl.sv
// Sequencing state machine of the traffic light color vote unit.
module tlcv_ctrl import tlcv_pkg::*; #(
  parameter int SUM_W = 29
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int BW = $clog2(SUM_W + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_EVICT = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [BW-1:0] bit_cnt_r, bit_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.count_en = 1'b1;
          if (in_last) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.evict_needed) begin
          cmd.rd_oldest = 1'b1;
          state_nxt     = ST_EVICT;
        end else begin
          cmd.write_hist = 1'b1;
          state_nxt      = ST_LOAD;
        end
      end
      ST_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        bit_cnt_nxt  = BW'(SUM_W);
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        bit_cnt_nxt  = bit_cnt_r - BW'(1);
        if (bit_cnt_r == BW'(1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold the quotients until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/tlcv_dp.sv
// Counting, history window, serial division and result registers of the color vote.
module tlcv_dp import tlcv_pkg::*; #(
  parameter int MAX_WINDOW = 32,
  parameter int COUNT_BITS = 23
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             hist_clear,
  input  logic [7:0]       hue,
  input  logic [7:0]       saturation,
  input  logic [7:0]       brightness,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  output logic             is_red,
  output logic [AVG_W-1:0] avg_red,
  output logic [AVG_W-1:0] avg_green
);

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FW    = $clog2(MAX_WINDOW + 1);
  localparam int OW    = $clog2(2 * MAX_WINDOW + 1);
  localparam int SUM_W = COUNT_BITS + FW;
  localparam int ENT_W = 2 * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] red_cnt_r, green_cnt_r;
  logic [AW-1:0]         head_r;
  logic [FW-1:0]         fill_r;
  logic [SUM_W-1:0]      red_sum_r, green_sum_r;
  logic [ENT_W-1:0]      hist_mem [MAX_WINDOW];
  logic [ENT_W-1:0]      rd_data_r;
  logic [SUM_W-1:0]      q_red_r, q_green_r;
  logic [FW-1:0]         rem_red_r, rem_green_r;
  logic                  is_red_r;
  logic [AVG_W-1:0]      avg_red_r, avg_green_r;

  // One restoring division step: returns {quotient bit, new remainder}
  function automatic logic [FW:0] div_bit(input logic [FW-1:0] rem,
                                          input logic          msb,
                                          input logic [FW-1:0] dvsr);
    logic [FW:0] shifted;
    logic [FW:0] diff;
    shifted = {rem, msb};
    diff    = shifted - {1'b0, dvsr};
    if (shifted >= {1'b0, dvsr}) div_bit = {1'b1, diff[FW-1:0]};
    else                         div_bit = {1'b0, shifted[FW-1:0]};
  endfunction

  // Pixel classification
  logic colored, red_pix, green_pix;
  assign colored   = (saturation >= cfg.sat_min) && (brightness >= cfg.val_min);
  assign red_pix   = colored && (hue <= cfg.red_hue_max);
  assign green_pix = colored && !red_pix && (hue >= cfg.green_hue_min) &&
                     (hue <= cfg.green_hue_max);

  // Saturating count updates
  logic [COUNT_BITS:0]   red_add;
  logic [COUNT_BITS-1:0] red_sat, green_sat;
  assign red_add   = {1'b0, red_cnt_r} + (COUNT_BITS + 1)'(cfg.red_weight);
  assign red_sat   = red_add[COUNT_BITS] ? COUNT_MAX : red_add[COUNT_BITS-1:0];
  assign green_sat = (green_cnt_r == COUNT_MAX) ? COUNT_MAX : green_cnt_r + 1'b1;

  // Clamp the window length to one .. MAX_WINDOW
  logic [FW-1:0] len_eff;
  always_comb begin
    if (cfg.window_len == '0)                 len_eff = FW'(1);
    else if (32'(cfg.window_len) > MAX_WINDOW) len_eff = FW'(MAX_WINDOW);
    else                                      len_eff = FW'(cfg.window_len);
  end

  assign status.evict_needed = (fill_r >= len_eff);

  // Oldest slot is head minus fill, modulo the ring size
  logic [OW-1:0] old_raw, old_mod;
  logic [AW-1:0] old_slot;
  assign old_raw  = OW'(head_r) + OW'(MAX_WINDOW) - OW'(fill_r);
  assign old_mod  = (old_raw >= OW'(MAX_WINDOW)) ? old_raw - OW'(MAX_WINDOW) : old_raw;
  assign old_slot = old_mod[AW-1:0];

  logic [AW-1:0] head_nxt;
  assign head_nxt = (head_r == AW'(MAX_WINDOW - 1)) ? '0 : head_r + 1'b1;

  // History ring: red count in the upper half, green in the lower
  always_ff @(posedge clk) begin
    if (cmd.write_hist) hist_mem[head_r] <= {red_cnt_r, green_cnt_r};
    if (cmd.rd_oldest)  rd_data_r <= hist_mem[old_slot];
  end

  // Box counts, ring pointers and window sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_cnt_r   <= '0;
      green_cnt_r <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      red_sum_r   <= '0;
      green_sum_r <= '0;
    end else begin
      if (cmd.count_en) begin
        if (red_pix)        red_cnt_r   <= red_sat;
        else if (green_pix) green_cnt_r <= green_sat;
      end
      if (cmd.write_hist) begin
        red_cnt_r   <= '0;
        green_cnt_r <= '0;
      end
      if (hist_clear) begin
        head_r      <= '0;
        fill_r      <= '0;
        red_sum_r   <= '0;
        green_sum_r <= '0;
      end else if (cmd.evict) begin
        red_sum_r   <= red_sum_r - SUM_W'(rd_data_r[ENT_W-1:COUNT_BITS]);
        green_sum_r <= green_sum_r - SUM_W'(rd_data_r[COUNT_BITS-1:0]);
        fill_r      <= fill_r - 1'b1;
      end else if (cmd.write_hist) begin
        red_sum_r   <= red_sum_r + SUM_W'(red_cnt_r);
        green_sum_r <= green_sum_r + SUM_W'(green_cnt_r);
        head_r      <= head_nxt;
        fill_r      <= fill_r + 1'b1;
      end
    end
  end

  // Two serial dividers sharing the fill count as divisor
  logic [FW:0] step_red, step_green;
  assign step_red   = div_bit(rem_red_r, q_red_r[SUM_W-1], fill_r);
  assign step_green = div_bit(rem_green_r, q_green_r[SUM_W-1], fill_r);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_red_r     <= red_sum_r;
      q_green_r   <= green_sum_r;
      rem_red_r   <= '0;
      rem_green_r <= '0;
    end else if (cmd.div_step) begin
      q_red_r     <= {q_red_r[SUM_W-2:0], step_red[FW]};
      q_green_r   <= {q_green_r[SUM_W-2:0], step_green[FW]};
      rem_red_r   <= step_red[FW-1:0];
      rem_green_r <= step_green[FW-1:0];
    end
  end

  // Result register: compare on full quotients, report the low bits
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      is_red_r    <= (q_red_r > q_green_r);
      avg_red_r   <= AVG_W'(q_red_r);
      avg_green_r <= AVG_W'(q_green_r);
    end
  end

  assign is_red    = is_red_r;
  assign avg_red   = avg_red_r;
  assign avg_green = avg_green_r;

endmodule

>>> bench/tlcv_vote_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the color vote unit: predicts each box vote and checks every result beat.
module tlcv_vote_checker import tlcv_pkg::*; #(
  parameter int MAX_WINDOW = 32,
  parameter int COUNT_BITS = 23
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tlcv_pixel_if                 pix,
  tlcv_result_if                res,
  output int                    mismatch_count,
  output int                    votes_pending,
  output int                    votes_checked
);

  localparam int SUM_W = COUNT_BITS + $clog2(MAX_WINDOW + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_CEIL = '1;

  typedef struct packed {
    logic             is_red;
    logic [AVG_W-1:0] avg_red;
    logic [AVG_W-1:0] avg_green;
  } vote_t;

  cfg_t                   cfg;
  logic [COUNT_BITS-1:0]  box_red;
  logic [COUNT_BITS-1:0]  box_green;
  logic [COUNT_BITS-1:0]  red_ring [MAX_WINDOW];
  logic [COUNT_BITS-1:0]  green_ring [MAX_WINDOW];
  int unsigned            ring_head;
  int unsigned            ring_fill;
  logic [SUM_W-1:0]       red_sum;
  logic [SUM_W-1:0]       green_sum;
  vote_t                  expected_votes [$];
  int                     errors = 0;
  int                     checked = 0;

  // Add to a box count, holding at the top of the count range
  function automatic logic [COUNT_BITS-1:0] count_add(input logic [COUNT_BITS-1:0] acc,
                                                      input logic [3:0] inc);
    logic [COUNT_BITS:0] total;
    total = {1'b0, acc} + inc;
    return (total > COUNT_CEIL) ? COUNT_CEIL : total[COUNT_BITS-1:0];
  endfunction

  // Boxes averaged: zero acts as one, anything past the ring acts as the ring size
  function automatic int unsigned window_depth();
    if (cfg.window_len == 0) return 1;
    if (cfg.window_len > MAX_WINDOW) return MAX_WINDOW;
    return cfg.window_len;
  endfunction

  // Classify one pixel; at a box end push its counts into the window and form the vote
  task automatic count_pixel_and_vote(input logic [7:0] hue, input logic [7:0] sat,
                                      input logic [7:0] val, input logic last);
    logic             colored;
    int unsigned      depth;
    int unsigned      oldest;
    logic [SUM_W-1:0] q_red;
    logic [SUM_W-1:0] q_green;
    vote_t            vote;
    colored = (sat >= cfg.sat_min) && (val >= cfg.val_min);
    if (colored && hue <= cfg.red_hue_max)
      box_red = count_add(box_red, cfg.red_weight);
    else if (colored && hue >= cfg.green_hue_min && hue <= cfg.green_hue_max)
      box_green = count_add(box_green, 4'd1);
    if (last) begin
      depth = window_depth();
      // Drop the oldest boxes until the new one fits
      while (ring_fill >= depth) begin
        oldest    = (ring_head + MAX_WINDOW - ring_fill) % MAX_WINDOW;
        red_sum   = red_sum - red_ring[oldest];
        green_sum = green_sum - green_ring[oldest];
        ring_fill--;
      end
      red_ring[ring_head]   = box_red;
      green_ring[ring_head] = box_green;
      red_sum   = red_sum + box_red;
      green_sum = green_sum + box_green;
      ring_head = (ring_head + 1) % MAX_WINDOW;
      ring_fill++;
      box_red   = '0;
      box_green = '0;
      q_red   = red_sum / ring_fill;
      q_green = green_sum / ring_fill;
      vote.is_red    = q_red > q_green;
      vote.avg_red   = q_red[AVG_W-1:0];
      vote.avg_green = q_green[AVG_W-1:0];
      expected_votes.insert(expected_votes.size(), vote);
    end
  endtask

  always @(posedge clk) begin : watch
    vote_t want;
    if (!rst_n) begin
      cfg.window_len    = WINDOW_LEN_RST;
      cfg.red_hue_max   = RED_HUE_MAX_RST;
      cfg.green_hue_min = GREEN_HUE_MIN_RST;
      cfg.green_hue_max = GREEN_HUE_MAX_RST;
      cfg.sat_min       = SAT_MIN_RST;
      cfg.val_min       = VAL_MIN_RST;
      cfg.red_weight    = RED_WEIGHT_RST;
      box_red   = '0;
      box_green = '0;
      ring_head = 0;
      ring_fill = 0;
      red_sum   = '0;
      green_sum = '0;
      expected_votes.delete();
    end else begin
      // Compare a result beat against the oldest pending vote
      if (res.valid && res.ready) begin
        if (expected_votes.size() == 0) begin
          $error("unexpected result beat: is_red %0b avg_red %0d avg_green %0d",
                 res.is_red, res.avg_red, res.avg_green);
          errors++;
        end else begin
          want = expected_votes[0];
          expected_votes.delete(0);
          checked++;
          if (res.is_red !== want.is_red) begin
            $error("is_red mismatch: expected %0b, actual %0b", want.is_red, res.is_red);
            errors++;
          end
          if (res.avg_red !== want.avg_red) begin
            $error("avg_red mismatch: expected %0d, actual %0d", want.avg_red, res.avg_red);
            errors++;
          end
          if (res.avg_green !== want.avg_green) begin
            $error("avg_green mismatch: expected %0d, actual %0d",
                   want.avg_green, res.avg_green);
            errors++;
          end
        end
      end
      // Track register writes; a window length write empties the history
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WINDOW_LEN: begin
            cfg.window_len = cfg_data[5:0];
            ring_head = 0;
            ring_fill = 0;
            red_sum   = '0;
            green_sum = '0;
          end
          REG_RED_HUE_MAX:   cfg.red_hue_max   = cfg_data;
          REG_GREEN_HUE_MIN: cfg.green_hue_min = cfg_data;
          REG_GREEN_HUE_MAX: cfg.green_hue_max = cfg_data;
          REG_SAT_MIN:       cfg.sat_min       = cfg_data;
          REG_VAL_MIN:       cfg.val_min       = cfg_data;
          REG_RED_WEIGHT:    cfg.red_weight    = cfg_data[3:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready)
        count_pixel_and_vote(pix.hue, pix.saturation, pix.brightness, pix.last_pixel);
    end
    mismatch_count <= errors;
    votes_pending  <= expected_votes.size();
    votes_checked  <= checked;
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Test top of the color vote unit: clock, reset, pixel and register stimulus, verdict.
module tb_top import tlcv_pkg::*; ();

  localparam int HALF_PERIOD  = 10;
  // Margin for a box end to run through eviction and the serial dividers
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 5_000_000;
  // One long box of full-weight red pixels for a large red average
  localparam int LONG_BOX_PIXELS = 48;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam cfg_t CFG_RESET = cfg_t'{WINDOW_LEN_RST, RED_HUE_MAX_RST, GREEN_HUE_MIN_RST,
                                      GREEN_HUE_MAX_RST, SAT_MIN_RST, VAL_MIN_RST,
                                      RED_WEIGHT_RST};

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    checked;

  cfg_t cur_cfg;
  bit   gaps_on = 1'b1;
  bit   stalls_on = 1'b1;
  int   stall_left = 0;
  int   pixels_sent = 0;
  int   boxes_sent = 0;
  int   settings_applied = 0;

  tlcv_pixel_if  pix_if ();
  tlcv_result_if res_if ();

  traffic_light_color_vote_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pix    (pix_if),
    .out_res   (res_if)
  );

  tlcv_vote_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pix            (pix_if),
    .res            (res_if),
    .mismatch_count (fail_count),
    .votes_pending  (pending),
    .votes_checked  (checked)
  );

  always #HALF_PERIOD clk = ~clk;

  // Idle stretch length: mostly short, now and then long
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
  endfunction

  // Backpressure on the result side
  always @(posedge clk) begin
    if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 99) < 20) begin
      res_if.ready <= 1'b0;
      stall_left   <= idle_len() - 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Hard stop for a hung run
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Saturation or brightness level clustered around a threshold
  function automatic logic [7:0] near_min(input logic [7:0] floor_v);
    case ($urandom_range(0, 9))
      0:       return floor_v - 8'd1;
      1:       return floor_v;
      2, 3:    return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(floor_v, 255));
    endcase
  endfunction

  // Pixel aimed at the red band, the green band, a band edge or anywhere
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: p.hue = 8'($urandom_range(0, cur_cfg.red_hue_max));
      3, 4, 5: p.hue = 8'($urandom_range(cur_cfg.green_hue_min, cur_cfg.green_hue_max));
      6: begin
        case ($urandom_range(0, 5))
          0:       p.hue = cur_cfg.red_hue_max;
          1:       p.hue = cur_cfg.red_hue_max + 8'd1;
          2:       p.hue = cur_cfg.green_hue_min - 8'd1;
          3:       p.hue = cur_cfg.green_hue_min;
          4:       p.hue = cur_cfg.green_hue_max;
          default: p.hue = cur_cfg.green_hue_max + 8'd1;
        endcase
      end
      default: p.hue = 8'($urandom_range(0, 255));
    endcase
    p.sat = near_min(cur_cfg.sat_min);
    p.val = near_min(cur_cfg.val_min);
    return p;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.window_len    = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(1, 8));
    c.red_hue_max   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 40));
    c.green_hue_min = 8'($urandom_range(30, 100));
    c.green_hue_max = 8'($urandom_range(60, 179));
    c.sat_min       = 8'($urandom_range(0, 200));
    c.val_min       = 8'($urandom_range(0, 200));
    c.red_weight    = 4'($urandom_range(0, 15));
    return c;
  endfunction

  // Offer one pixel beat, maybe after a gap, and hold it until taken
  task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                            input logic [7:0] val, input logic last);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid      <= 1'b1;
    pix_if.hue        <= hue;
    pix_if.saturation <= sat;
    pix_if.brightness <= val;
    pix_if.last_pixel <= last;
    do @(posedge clk); while (!pix_if.ready);
    pixels_sent++;
    if (last) boxes_sent++;
  endtask

  // Drop valid and wait until every vote is back and the datapath has gone quiet
  task automatic settle();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Load the register set once idle, the window length only if set_window; junk goes in the unused high bits
  task automatic apply_cfg(input cfg_t c, input bit set_window);
    logic [1:0] hi2;
    logic [3:0] hi4;
    hi2 = 2'($urandom_range(0, 3));
    hi4 = 4'($urandom_range(0, 15));
    settle();
    if (set_window) write_reg(REG_WINDOW_LEN, {hi2, c.window_len});
    else c.window_len = cur_cfg.window_len;
    write_reg(REG_RED_HUE_MAX, c.red_hue_max);
    write_reg(REG_GREEN_HUE_MIN, c.green_hue_min);
    write_reg(REG_GREEN_HUE_MAX, c.green_hue_max);
    write_reg(REG_SAT_MIN, c.sat_min);
    write_reg(REG_VAL_MIN, c.val_min);
    write_reg(REG_RED_WEIGHT, {hi4, c.red_weight});
    cfg_wr_en <= 1'b0;
    cur_cfg = c;
    settings_applied++;
    gaps_on   = $urandom_range(0, 3) != 0;
    stalls_on = $urandom_range(0, 3) != 0;
  endtask

  // Random boxes until about n_items pixels went out; the last box always closes
  task automatic run_boxes(input int n_items, input bit tiny_boxes);
    int     sent;
    int     box_len;
    int     r;
    pixel_t p;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      if (tiny_boxes)  box_len = $urandom_range(1, 3);
      else if (r < 6)  box_len = $urandom_range(1, 6);
      else if (r < 9)  box_len = $urandom_range(7, 20);
      else             box_len = $urandom_range(21, 60);
      for (int i = 0; i < box_len; i++) begin
        p = random_pixel();
        send_pixel(p.hue, p.sat, p.val, i == box_len - 1);
      end
      sent += box_len;
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    pix_if.valid      = 1'b0;
    pix_if.hue        = '0;
    pix_if.saturation = '0;
    pix_if.brightness = '0;
    pix_if.last_pixel = 1'b0;
    res_if.ready      = 1'b0;
    cur_cfg           = CFG_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset thresholds: band edges, dim and pale pixels, out-of-range hue
    send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
    send_pixel(8'd10,  8'd100, 8'd100, 1'b0);
    send_pixel(8'd11,  8'd255, 8'd255, 1'b0);
    send_pixel(8'd39,  8'd255, 8'd255, 1'b0);
    send_pixel(8'd40,  8'd100, 8'd100, 1'b0);
    send_pixel(8'd80,  8'd255, 8'd255, 1'b0);
    send_pixel(8'd81,  8'd255, 8'd255, 1'b0);
    send_pixel(8'd5,   8'd99,  8'd255, 1'b0);
    send_pixel(8'd5,   8'd255, 8'd99,  1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd60,  8'd255, 8'd255, 1'b1);
    send_pixel(8'd0,   8'd0,   8'd0,   1'b1);
    send_pixel(8'd180, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0,   8'd255, 8'd255, 1'b1);

    // One-box window, overlapping bands (red wins), full weight, strictest minimums
    apply_cfg(cfg_t'{6'd1, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 4'd15}, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd1, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd254, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b1);
    // Zero red weight: red pixels count nothing
    apply_cfg(cfg_t'{6'd1, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 4'd0}, 1'b0);
    send_pixel(8'd0,  8'd255, 8'd255, 1'b0);
    send_pixel(8'd50, 8'd255, 8'd255, 1'b1);

    // Fixed corners of the register space
    apply_cfg(CFG_RESET, 1'b1);
    run_boxes(80, 1'b0);
    apply_cfg(cfg_t'{6'd1, 8'd20, 8'd30, 8'd90, 8'd50, 8'd50, 4'd0}, 1'b1);
    run_boxes(60, 1'b0);
    apply_cfg(cfg_t'{6'd32, 8'd179, 8'd0, 8'd255, 8'd0, 8'd0, 4'd15}, 1'b1);
    run_boxes(80, 1'b1);

    // Reopen the window while a box is half counted; its counts must survive
    for (int i = 0; i < 3; i++) send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    settle();
    write_reg(REG_WINDOW_LEN, 8'd33);
    cfg_wr_en <= 1'b0;
    cur_cfg.window_len = 6'd33;
    send_pixel(8'd60, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd5,  8'd255, 8'd255, 1'b1);

    // Write to an index with no register behind it
    settle();
    write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_wr_en <= 1'b0;
    run_boxes(20, 1'b1);

    // Zero window, empty green band; then an oversized window with single-hue bands
    apply_cfg(cfg_t'{6'd0, 8'd10, 8'd100, 8'd50, 8'd255, 8'd255, 4'd7}, 1'b1);
    run_boxes(50, 1'b0);
    apply_cfg(cfg_t'{6'd63, 8'd0, 8'd179, 8'd179, 8'd128, 8'd1, 4'd3}, 1'b1);
    run_boxes(90, 1'b1);

    // New thresholds over a kept history, then random settings
    apply_cfg(random_cfg(), 1'b0);
    run_boxes(60, 1'b0);
    repeat (4) begin
      apply_cfg(random_cfg(), 1'($urandom_range(0, 1)));
      run_boxes(50, 1'b0);
    end

    // One long full-weight red box back to back, then average it with short boxes
    apply_cfg(cfg_t'{6'd2, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 4'd15}, 1'b1);
    gaps_on = 1'b0;
    for (int i = 0; i < LONG_BOX_PIXELS; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == LONG_BOX_PIXELS - 1);
    gaps_on = 1'b1;
    run_boxes(10, 1'b1);

    settle();
    $display("Run covered %0d pixels in %0d boxes over %0d register settings,",
             pixels_sent, boxes_sent, settings_applied);
    $display("with %0d color votes compared against the prediction.", checked);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/tlcv_pkg.sv
hw/rtl/tlcv_if.sv
hw/rtl/tlcv_cfg.sv
hw/rtl/tlcv_ctrl.sv
hw/rtl/tlcv_dp.sv
hw/rtl/traffic_light_color_vote_unit.sv
bench/tlcv_vote_checker.sv
bench/tb_top.sv
